>>> rtl/swrl_pkg.sv
`timescale 1ns / 1ps

package swrl_pkg;

   // Configuration register indexes.
   localparam logic CSR_MAX_REQUESTS = 1'b0;
   localparam logic CSR_WINDOW_TICKS = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam int MAX_REQ_W   = 7;
   localparam int WINDOW_W    = 32;
   localparam int NOW_W       = 32;
   localparam int COUNT_OUT_W = 7;

   localparam logic [MAX_REQ_W-1:0] MAX_REQ_RESET = 7'd64;
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 32'd1000000;

   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

endpackage

>>> rtl/sliding_window_rate_limiter_core.sv
// Sliding-window-log rate limiter. Grant times are kept as a ring of time stamps in a
// single-port-write, registered-read RAM of RING_DEPTH entries. Each item transfers in
// the idle state and then passes through the work state, so a new request can transfer
// only once the block is back in idle. A release finishes in the work state once the
// result register is free, and its result is valid from the cycle after that. An
// acquire first drops the expired stamps from the head of the ring, where each drop
// costs one RAM read of the next head stamp, and then makes its limit check. Every
// stamp is dropped at most once. One item is in work at a time; the result register
// lets the next request transfer while the previous result still waits, and a work
// step that would produce a result waits until that register is free. Configuration
// writes are always taken and should only be issued while the block is idle.
`timescale 1ns / 1ps

module sliding_window_rate_limiter_core
   import swrl_pkg::*;
#(
   parameter int RING_DEPTH = 64,
   parameter int TIME_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_operation,
   input  logic [NOW_W-1:0]       req_now_ticks,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_granted,
   output logic [COUNT_OUT_W-1:0] rsp_count_after,
   output logic                   rsp_overloaded,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;
   localparam int LIM_W = (CNT_W > MAX_REQ_W) ? CNT_W : MAX_REQ_W;
   localparam int OVL_W = (CNT_W + 3 > MAX_REQ_W + 2) ? CNT_W + 3 : MAX_REQ_W + 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

   state_type state_ff, state_in;

   logic                 op_ff;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic [MAX_REQ_W-1:0] max_ff;
   logic [WINDOW_W-1:0]  window_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_granted_ff, rsp_granted_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_overloaded_ff, rsp_overloaded_in;

   logic                 req_fire;
   logic                 out_free;
   logic                 stale;
   logic                 below_limit;
   logic [TIME_BITS-1:0] age;
   logic [TIME_BITS-1:0] head_stamp;
   logic                 ram_wr_en;

   swrl_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (RING_DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (now_ff),
      .rd_addr (head_in),
      .rd_data (head_stamp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The RAM always reads at the next head, so in the work state its output is the
   // stamp of the current oldest entry.
   assign age         = now_ff - head_stamp;
   assign stale       = (count_ff != '0) && (CMP_W'(age) > CMP_W'(window_ff));
   assign below_limit = (LIM_W'(count_ff) < LIM_W'(max_ff)) && (count_ff != FULL_CNT);

   always_comb begin
      state_in          = state_ff;
      now_in            = now_ff;
      head_in           = head_ff;
      tail_in           = tail_ff;
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_granted_in    = rsp_granted_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_overloaded_in = rsp_overloaded_ff;
      ram_wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in   = TIME_BITS'(req_now_ticks);
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (op_ff == OP_ACQUIRE && stale) begin
               head_in  = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end else if (out_free) begin
               rsp_granted_in = 1'b0;
               if (op_ff == OP_ACQUIRE) begin
                  if (below_limit) begin
                     ram_wr_en      = 1'b1;
                     tail_in        = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                     count_in       = count_ff + 1'b1;
                     rsp_granted_in = 1'b1;
                  end
               end else if (count_ff != '0) begin
                  head_in        = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                  count_in       = count_ff - 1'b1;
                  rsp_granted_in = 1'b1;
               end
               rsp_valid_in      = 1'b1;
               rsp_count_in      = COUNT_OUT_W'(count_in);
               rsp_overloaded_in = (OVL_W'(count_in) * OVL_W'(5)) >=
                                   (OVL_W'(max_ff) * OVL_W'(4));
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_operation;
      end
      now_ff            <= now_in;
      rsp_granted_ff    <= rsp_granted_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_overloaded_ff <= rsp_overloaded_in;
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= MAX_REQ_RESET;
         window_ff <= WINDOW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_REQUESTS: max_ff    <= csr_wdata[MAX_REQ_W-1:0];
            CSR_WINDOW_TICKS: window_ff <= csr_wdata[WINDOW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = rsp_granted_ff;
   assign rsp_count_after = rsp_count_ff;
   assign rsp_overloaded  = rsp_overloaded_ff;

endmodule

>>> rtl/swrl_ram.sv
`timescale 1ns / 1ps

module swrl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> verif/tb_sliding_window_rate_limiter_core.sv
`timescale 1ns / 1ps

module tb_sliding_window_rate_limiter_core;
   import swrl_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int TIME_BITS  = 32;
   localparam int EXP_DEPTH  = 16;

   typedef struct packed {
      logic                   granted;
      logic [COUNT_OUT_W-1:0] count_after;
      logic                   overloaded;
   } verdict_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_operation;
   logic [NOW_W-1:0]       req_now_ticks;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_granted;
   logic [COUNT_OUT_W-1:0] rsp_count_after;
   logic                   rsp_overloaded;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Mirror of the limiter: the stamp log, its pointers and the live settings.
   logic [NOW_W-1:0]     stamp_log [RING_DEPTH];
   logic [5:0]           log_head;
   logic [5:0]           log_tail;
   int                   log_count;
   logic [MAX_REQ_W-1:0] cfg_max_req;
   logic [WINDOW_W-1:0]  cfg_window;

   // Expected results in transfer order; the two counts only ever grow.
   verdict_type      expected_ring [EXP_DEPTH];
   int               exp_wr_count;
   int               exp_rd_count;
   int               mismatch_count;
   bit               calm_mode;
   logic [NOW_W-1:0] tick_now;

   always #6 clock = ~clock;

   sliding_window_rate_limiter_core #(
      .RING_DEPTH(RING_DEPTH),
      .TIME_BITS (TIME_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_now_ticks  (req_now_ticks),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_granted    (rsp_granted),
      .rsp_count_after(rsp_count_after),
      .rsp_overloaded (rsp_overloaded),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   function automatic int outstanding();
      return exp_wr_count - exp_rd_count;
   endfunction

   function automatic verdict_type apply_rate_rule(logic op, logic [NOW_W-1:0] now);
      verdict_type      v;
      logic [NOW_W-1:0] age;
      int               limit;
      bit               expired;
      v.granted = 1'b0;
      limit = (cfg_max_req > RING_DEPTH) ? RING_DEPTH : int'(cfg_max_req);
      if (op == OP_ACQUIRE) begin
         // Stamps older than the window leave from the head before the limit check.
         // Ages wrap, so a stamp from the future looks very old.
         expired = 1'b1;
         while (expired && log_count > 0) begin
            age = now - stamp_log[log_head];
            if (age > cfg_window) begin
               log_head++;
               log_count--;
            end else begin
               expired = 1'b0;
            end
         end
         if (log_count < limit) begin
            stamp_log[log_tail] = now;
            log_tail++;
            log_count++;
            v.granted = 1'b1;
         end
      end else if (log_count > 0) begin
         log_head++;
         log_count--;
         v.granted = 1'b1;
      end
      v.count_after = log_count[COUNT_OUT_W-1:0];
      v.overloaded  = (5 * log_count >= 4 * int'(cfg_max_req));
      return v;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outstanding() == 0) begin
            report_mismatch("result with nothing outstanding, count_after",
                            rsp_count_after, 0);
         end else begin
            want = expected_ring[exp_rd_count % EXP_DEPTH];
            exp_rd_count++;
            if (rsp_granted !== want.granted)
               report_mismatch("granted", rsp_granted, want.granted);
            if (rsp_count_after !== want.count_after)
               report_mismatch("count_after", rsp_count_after, want.count_after);
            if (rsp_overloaded !== want.overloaded)
               report_mismatch("overloaded", rsp_overloaded, want.overloaded);
         end
      end
   end

   // The result side stalls in bursts, except in the calm part of the run.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm_mode && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic push_request(logic op, logic [NOW_W-1:0] now);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_now_ticks <= now;
      do @(posedge clock); while (!req_ready);
      expected_ring[exp_wr_count % EXP_DEPTH] = apply_rate_rule(op, now);
      exp_wr_count++;
      if (!calm_mode && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MAX_REQUESTS)
         cfg_max_req = value[MAX_REQ_W-1:0];
      else
         cfg_window = value[WINDOW_W-1:0];
      @(posedge clock);
   endtask

   // Settings change only once every outstanding result has been returned.
   // Bits above the limit field are random so that the write must mask them.
   task automatic set_limits(logic [MAX_REQ_W-1:0] max_req, logic [WINDOW_W-1:0] window);
      logic [CSR_DATA_W-1:0] max_word;
      wait_for_idle();
      max_word = $urandom();
      max_word[MAX_REQ_W-1:0] = max_req;
      write_register(CSR_MAX_REQUESTS, max_word);
      write_register(CSR_WINDOW_TICKS, window);
   endtask

   task automatic test_default_config();
      push_request(OP_ACQUIRE, 32'h0000_0000);
      push_request(OP_ACQUIRE, 32'hFFFF_FFFF);
      push_request(OP_RELEASE, 32'h0000_1234);
      push_request(OP_RELEASE, 32'hFFFF_FFFF);
      wait_for_idle();
   endtask

   task automatic test_zero_limit();
      set_limits(7'd0, 32'd1000);
      push_request(OP_ACQUIRE, 32'd10);
      push_request(OP_RELEASE, 32'd11);
      wait_for_idle();
   endtask

   task automatic test_zero_window();
      set_limits(7'd3, 32'd0);
      repeat (4) push_request(OP_ACQUIRE, 32'd5);
      push_request(OP_ACQUIRE, 32'd6);
      wait_for_idle();
   endtask

   task automatic test_time_wraparound();
      set_limits(7'd3, 32'd100);
      push_request(OP_ACQUIRE, 32'hFFFF_FFF0);
      push_request(OP_ACQUIRE, 32'h0000_0010);
      push_request(OP_ACQUIRE, 32'h0000_0008);
      push_request(OP_ACQUIRE, 32'h0000_0005);
      push_request(OP_RELEASE, 32'h0000_0006);
      push_request(OP_RELEASE, 32'h0000_0006);
      // The head stamp now lies one tick in the future.
      push_request(OP_ACQUIRE, 32'h0000_0007);
      wait_for_idle();
   endtask

   task automatic test_limit_above_depth();
      set_limits(7'd127, 32'hFFFF_FFFF);
      push_request(OP_ACQUIRE, 32'd0);
      push_request(OP_ACQUIRE, 32'd1);
      push_request(OP_RELEASE, 32'd2);
      wait_for_idle();
   endtask

   task automatic test_random_traffic(int phases, int items_per_phase);
      logic [MAX_REQ_W-1:0] max_req;
      logic [WINDOW_W-1:0]  window;
      int                   release_pct;
      int unsigned          span;
      logic                 op;
      for (int p = 0; p < phases; p++) begin
         if (p == 0) begin
            // An endless window with a limit above the depth fills the whole ring.
            max_req     = MAX_REQ_W'($urandom_range(65, 127));
            window      = 32'hFFFF_FFFF;
            release_pct = 8;
         end else begin
            case ($urandom_range(0, 7))
               0:       max_req = 7'd0;
               1:       max_req = MAX_REQ_W'($urandom_range(1, 3));
               5:       max_req = 7'd64;
               6:       max_req = MAX_REQ_W'($urandom_range(65, 127));
               7:       max_req = MAX_REQ_W'($urandom_range(17, 63));
               default: max_req = MAX_REQ_W'($urandom_range(4, 16));
            endcase
            case ($urandom_range(0, 5))
               0:       window = 32'd0;
               1:       window = $urandom_range(1, 16);
               2:       window = $urandom_range(17, 1000);
               3:       window = $urandom_range(1001, 1000000);
               4:       window = $urandom();
               default: window = 32'hFFFF_FFFF;
            endcase
            release_pct = $urandom_range(5, 40);
         end
         if (p >= phases - 2)
            calm_mode = 1'b1;
         set_limits(max_req, window);
         span = (window >> 3) + 2;
         for (int i = 0; i < items_per_phase; i++) begin
            case ($urandom_range(0, 9))
               0:       tick_now = tick_now;
               1:       tick_now = $urandom();
               default: tick_now = tick_now + $urandom_range(0, span);
            endcase
            op = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_ACQUIRE;
            push_request(op, tick_now);
            if ($urandom_range(0, 99) == 0)
               wait_for_idle();
         end
      end
   endtask

   task automatic await_last_results();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (outstanding() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (outstanding() != 0)
         report_mismatch("results never returned", 0, outstanding());
      repeat (16) @(posedge clock);
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_ACQUIRE;
      req_now_ticks <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_MAX_REQUESTS;
      csr_wdata     <= '0;
      log_head       = '0;
      log_tail       = '0;
      log_count      = 0;
      cfg_max_req    = MAX_REQ_RESET;
      cfg_window     = WINDOW_RESET;
      exp_wr_count   = 0;
      exp_rd_count   = 0;
      mismatch_count = 0;
      calm_mode      = 1'b0;
      tick_now       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_config();
      test_zero_limit();
      test_zero_window();
      test_time_wraparound();
      test_limit_above_depth();
      test_random_traffic(12, 86);
      await_last_results();

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
rtl/swrl_pkg.sv
rtl/swrl_ram.sv
rtl/sliding_window_rate_limiter_core.sv
verif/tb_sliding_window_rate_limiter_core.sv
